FILE: sv/assert_macros.svh
// Assertion helpers for the dstfm_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/dstfm_pkg.sv
`timescale 1ns / 1ps
package dstfm_pkg;

   localparam int AdcBits     = 12;
   localparam int ReadingBits = 12;
   localparam int TicksBits   = 8;
   localparam int CodeBits    = 3;
   localparam int CsrIdxBits  = 4;

   // Readings wider than the converter are masked down to its resolution.
   localparam logic [ReadingBits-1:0] ReadMask =
      ReadingBits'((32'd1 << AdcBits) - 32'd1);

   localparam logic [TicksBits-1:0] PersistReset = TicksBits'(100);

   // Fault codes, lower value has priority
   localparam logic [CodeBits-1:0] CodeNone     = 3'd0;
   localparam logic [CodeBits-1:0] CodeExternal = 3'd1;
   localparam logic [CodeBits-1:0] CodeBus      = 3'd2;
   localparam logic [CodeBits-1:0] CodeHeatsink = 3'd3;
   localparam logic [CodeBits-1:0] CodeNtc      = 3'd4;
   localparam logic [CodeBits-1:0] CodeRail     = 3'd5;

   // Register indexes
   localparam logic [CsrIdxBits-1:0] RegBusHigh    = 4'd0;
   localparam logic [CsrIdxBits-1:0] RegBusLow     = 4'd1;
   localparam logic [CsrIdxBits-1:0] RegBusRecover = 4'd2;
   localparam logic [CsrIdxBits-1:0] RegHeatsink   = 4'd3;
   localparam logic [CsrIdxBits-1:0] RegNtc        = 4'd4;
   localparam logic [CsrIdxBits-1:0] RegRailLow    = 4'd5;
   localparam logic [CsrIdxBits-1:0] RegRailHigh   = 4'd6;
   localparam logic [CsrIdxBits-1:0] RegPersist    = 4'd7;

   typedef struct packed {
      logic                   tick;
      logic [ReadingBits-1:0] bus_reading;
      logic [ReadingBits-1:0] heatsink_reading;
      logic [ReadingBits-1:0] ntc_reading;
      logic [ReadingBits-1:0] rail_reading;
      logic                   external_fault;
   } req_payload_type;

   typedef struct packed {
      logic [CodeBits-1:0] fault_code;
      logic                save_request;
      logic                reset_request;
   } rsp_payload_type;

   function automatic logic [CodeBits-1:0] raise_code(input logic [CodeBits-1:0] held,
                                                      input logic [CodeBits-1:0] fresh);
      return (held == CodeNone || held > fresh) ? fresh : held;
   endfunction

   function automatic logic [TicksBits-1:0] count_down(input logic [TicksBits-1:0] cnt);
      return (cnt != '0) ? cnt - TicksBits'(1) : '0;
   endfunction

endpackage

FILE: sv/debounced_supply_temp_fault_monitor.sv
`timescale 1ns / 1ps
// Path: an accepted req beat enters the input register, then the check logic feeds the
//   result register. Throughput: 1 item per cycle while rsp_stall is low.
// The update is a compare level and a short priority mux chain.
// Reset (synchronous, active high): limits and reload value return to defaults,
//   counters load 100, fault latch and save flag clear, both pipeline stages empty.
module debounced_supply_temp_fault_monitor import dstfm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [ReadingBits-1:0] csr_wdata
);

   logic                   in_valid_ff;
   req_payload_type        in_data_ff;
   logic                   out_valid_ff;
   rsp_payload_type        out_data_ff, out_data_in;
   logic                   advance;

   logic [ReadingBits-1:0] bus_high_ff, bus_low_ff, bus_recover_ff;
   logic [ReadingBits-1:0] heatsink_limit_ff, ntc_limit_ff, rail_low_ff, rail_high_ff;
   logic [TicksBits-1:0]   persist_ff;

   logic [TicksBits-1:0]   bus_cnt_ff, hs_cnt_ff, ntc_cnt_ff, rail_cnt_ff;
   logic [TicksBits-1:0]   bus_cnt_in, hs_cnt_in, ntc_cnt_in, rail_cnt_in;
   logic [CodeBits-1:0]    code_ff, code_in;
   logic                   saved_ff, saved_in;

   logic [ReadingBits-1:0] bus_rd, hs_rd, ntc_rd, rail_rd;
   logic [TicksBits-1:0]   bus_dn, hs_dn, ntc_dn, rail_dn;
   logic                   bus_out, hs_out, ntc_out, rail_out;
   logic                   bus_fault;
   logic [CodeBits-1:0]    code_ext, code_bus, code_hs, code_ntc, code_rail;

   // Stage 2 moves when it holds an item and the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_high_ff       <= ReadingBits'(3800);
         bus_low_ff        <= ReadingBits'(2000);
         bus_recover_ff    <= ReadingBits'(2800);
         heatsink_limit_ff <= ReadingBits'(3000);
         ntc_limit_ff      <= ReadingBits'(1000);
         rail_low_ff       <= ReadingBits'(1000);
         rail_high_ff      <= ReadingBits'(1600);
         persist_ff        <= PersistReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            RegBusHigh:    bus_high_ff       <= csr_wdata;
            RegBusLow:     bus_low_ff        <= csr_wdata;
            RegBusRecover: bus_recover_ff    <= csr_wdata;
            RegHeatsink:   heatsink_limit_ff <= csr_wdata;
            RegNtc:        ntc_limit_ff      <= csr_wdata;
            RegRailLow:    rail_low_ff       <= csr_wdata;
            RegRailHigh:   rail_high_ff      <= csr_wdata;
            RegPersist:    persist_ff        <= csr_wdata[TicksBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_cnt_ff  <= PersistReset;
         hs_cnt_ff   <= PersistReset;
         ntc_cnt_ff  <= PersistReset;
         rail_cnt_ff <= PersistReset;
         code_ff     <= CodeNone;
         saved_ff    <= 1'b0;
      end else if (advance) begin
         bus_cnt_ff  <= bus_cnt_in;
         hs_cnt_ff   <= hs_cnt_in;
         ntc_cnt_ff  <= ntc_cnt_in;
         rail_cnt_ff <= rail_cnt_in;
         code_ff     <= code_in;
         saved_ff    <= saved_in;
      end
   end

   assign bus_rd  = in_data_ff.bus_reading & ReadMask;
   assign hs_rd   = in_data_ff.heatsink_reading & ReadMask;
   assign ntc_rd  = in_data_ff.ntc_reading & ReadMask;
   assign rail_rd = in_data_ff.rail_reading & ReadMask;

   assign bus_dn  = count_down(bus_cnt_ff);
   assign hs_dn   = count_down(hs_cnt_ff);
   assign ntc_dn  = count_down(ntc_cnt_ff);
   assign rail_dn = count_down(rail_cnt_ff);

   assign bus_out  = (bus_rd > bus_high_ff) || (bus_rd < bus_low_ff);
   assign hs_out   = hs_rd > heatsink_limit_ff;
   assign ntc_out  = ntc_rd < ntc_limit_ff;
   assign rail_out = (rail_rd < rail_low_ff) || (rail_rd > rail_high_ff);

   assign code_ext = in_data_ff.external_fault ? raise_code(code_ff, CodeExternal) : code_ff;

   // Bus overrides anything but an external fault, including codes below it in rank.
   assign bus_fault = bus_out && (bus_dn == '0) && (code_ext != CodeExternal);
   assign code_bus  = bus_fault ? CodeBus : code_ext;
   assign code_hs   = (hs_out && hs_dn == '0) ? raise_code(code_bus, CodeHeatsink) : code_bus;
   assign code_ntc  = (ntc_out && ntc_dn == '0) ? raise_code(code_hs, CodeNtc) : code_hs;
   assign code_rail = (rail_out && rail_dn == '0) ? raise_code(code_ntc, CodeRail) : code_ntc;

   always_comb begin
      bus_cnt_in  = bus_cnt_ff;
      hs_cnt_in   = hs_cnt_ff;
      ntc_cnt_in  = ntc_cnt_ff;
      rail_cnt_in = rail_cnt_ff;
      code_in     = code_ext;
      saved_in    = saved_ff;
      out_data_in.save_request  = 1'b0;
      out_data_in.reset_request = 1'b0;
      if (in_data_ff.tick) begin
         bus_cnt_in  = bus_out  ? bus_dn  : persist_ff;
         hs_cnt_in   = hs_out   ? hs_dn   : persist_ff;
         ntc_cnt_in  = ntc_out  ? ntc_dn  : persist_ff;
         rail_cnt_in = rail_out ? rail_dn : persist_ff;
         code_in     = code_rail;
         if (bus_fault) begin
            saved_in = 1'b1;
         end
         out_data_in.save_request  = bus_fault && !saved_ff;
         out_data_in.reset_request = !bus_out && (code_ext == CodeBus) &&
                                     (bus_rd > bus_recover_ff);
      end
      out_data_in.fault_code = code_in;
   end

endmodule

FILE: sv/dstfm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dstfm_checker import dstfm_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic                rsp_beat;
   logic                saw_save_ff;
   logic                saw_fault_ff;
   logic                rsp_pulse;
   logic [CodeBits-1:0] rsp_code;

   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign rsp_code  = rsp_payload.fault_code;
   assign rsp_pulse = rsp_payload.save_request || rsp_payload.reset_request;

   always_ff @(posedge clock) begin
      if (reset) begin
         saw_save_ff  <= 1'b0;
         saw_fault_ff <= 1'b0;
      end else if (rsp_beat) begin
         if (rsp_payload.save_request) begin
            saw_save_ff <= 1'b1;
         end
         if (rsp_payload.fault_code != CodeNone) begin
            saw_fault_ff <= 1'b1;
         end
      end
   end

   `CHK_IMPLIES(a_code_range, clock, reset, rsp_valid, rsp_code <= CodeRail)
   `CHK_IMPLIES(a_req_need_bus, clock, reset, rsp_valid && rsp_pulse, rsp_code == CodeBus)
   `CHK_IMPLIES(a_save_once, clock, reset, rsp_valid && saw_save_ff, !rsp_payload.save_request)
   `CHK_IMPLIES(a_latch_sticks, clock, reset, rsp_valid && saw_fault_ff, rsp_code != CodeNone)
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind debounced_supply_temp_fault_monitor dstfm_checker u_dstfm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

FILE: tb/sv/fault_monitor_checker.sv
`timescale 1ns / 1ps
module fault_monitor_checker import dstfm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CsrIdxBits-1:0]  csr_index,
   input  logic [ReadingBits-1:0] csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count
);

   localparam logic [ReadingBits-1:0] BusHighAtReset    = 12'd3800;
   localparam logic [ReadingBits-1:0] BusLowAtReset     = 12'd2000;
   localparam logic [ReadingBits-1:0] BusRecoverAtReset = 12'd2800;
   localparam logic [ReadingBits-1:0] HeatsinkAtReset   = 12'd3000;
   localparam logic [ReadingBits-1:0] NtcAtReset        = 12'd1000;
   localparam logic [ReadingBits-1:0] RailLowAtReset    = 12'd1000;
   localparam logic [ReadingBits-1:0] RailHighAtReset   = 12'd1600;

   logic [ReadingBits-1:0] lim_bus_high, lim_bus_low, lim_recover;
   logic [ReadingBits-1:0] lim_heatsink, lim_ntc, lim_rail_low, lim_rail_high;
   logic [TicksBits-1:0]   reload_ticks;
   logic [TicksBits-1:0]   cnt_bus, cnt_hs, cnt_ntc, cnt_rail;
   logic [CodeBits-1:0]    held_code;
   logic                   save_done;
   rsp_payload_type        expected_reports[$];

   function automatic logic [TicksBits-1:0] tick_down(input logic [TicksBits-1:0] c);
      if (c == '0) return '0;
      return c - TicksBits'(1);
   endfunction

   // lower code wins, an empty latch takes anything
   function automatic logic [CodeBits-1:0] prefer_lower(input logic [CodeBits-1:0] held,
                                                        input logic [CodeBits-1:0] fresh);
      if (held == CodeNone || held > fresh) return fresh;
      return held;
   endfunction

   task automatic report_mismatch(input string what, input logic [CodeBits-1:0] want,
                                  input logic [CodeBits-1:0] got);
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      fail_count++;
   endtask

   task automatic predict_report(input req_payload_type p, output rsp_payload_type r);
      logic [ReadingBits-1:0] bus, hs, ntc, rail;
      logic [CodeBits-1:0]    code;
      bus  = p.bus_reading & ReadMask;
      hs   = p.heatsink_reading & ReadMask;
      ntc  = p.ntc_reading & ReadMask;
      rail = p.rail_reading & ReadMask;
      code = held_code;
      r = '0;
      if (p.external_fault) code = prefer_lower(code, CodeExternal);
      if (p.tick) begin
         cnt_bus  = tick_down(cnt_bus);
         cnt_hs   = tick_down(cnt_hs);
         cnt_ntc  = tick_down(cnt_ntc);
         cnt_rail = tick_down(cnt_rail);
         // bus overrides everything but the external code
         if (bus > lim_bus_high || bus < lim_bus_low) begin
            if (cnt_bus == '0 && code != CodeExternal) begin
               code = CodeBus;
               if (!save_done) begin
                  save_done = 1'b1;
                  r.save_request = 1'b1;
               end
            end
         end else begin
            if (code == CodeBus && bus > lim_recover) r.reset_request = 1'b1;
            cnt_bus = reload_ticks;
         end
         if (hs > lim_heatsink) begin
            if (cnt_hs == '0) code = prefer_lower(code, CodeHeatsink);
         end else begin
            cnt_hs = reload_ticks;
         end
         if (ntc < lim_ntc) begin
            if (cnt_ntc == '0) code = prefer_lower(code, CodeNtc);
         end else begin
            cnt_ntc = reload_ticks;
         end
         if (rail < lim_rail_low || rail > lim_rail_high) begin
            if (cnt_rail == '0) code = prefer_lower(code, CodeRail);
         end else begin
            cnt_rail = reload_ticks;
         end
      end
      held_code = code;
      r.fault_code = code;
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_payload_type want;
      if (reset) begin
         lim_bus_high  = BusHighAtReset;
         lim_bus_low   = BusLowAtReset;
         lim_recover   = BusRecoverAtReset;
         lim_heatsink  = HeatsinkAtReset;
         lim_ntc       = NtcAtReset;
         lim_rail_low  = RailLowAtReset;
         lim_rail_high = RailHighAtReset;
         reload_ticks  = PersistReset;
         cnt_bus       = PersistReset;
         cnt_hs        = PersistReset;
         cnt_ntc       = PersistReset;
         cnt_rail      = PersistReset;
         held_code     = CodeNone;
         save_done     = 1'b0;
         expected_reports.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               RegBusHigh:    lim_bus_high  = csr_wdata;
               RegBusLow:     lim_bus_low   = csr_wdata;
               RegBusRecover: lim_recover   = csr_wdata;
               RegHeatsink:   lim_heatsink  = csr_wdata;
               RegNtc:        lim_ntc       = csr_wdata;
               RegRailLow:    lim_rail_low  = csr_wdata;
               RegRailHigh:   lim_rail_high = csr_wdata;
               RegPersist:    reload_ticks  = csr_wdata[TicksBits-1:0];
               default: ;
            endcase
         end
         // compare before pushing: a result can never belong to this edge's beat
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("result beat with nothing expected, code", CodeNone,
                               rsp_payload.fault_code);
            end else begin
               want = expected_reports.pop_front();
               checked_count++;
               if (rsp_payload.fault_code !== want.fault_code)
                  report_mismatch("fault_code", want.fault_code, rsp_payload.fault_code);
               if (rsp_payload.save_request !== want.save_request)
                  report_mismatch("save_request", CodeBits'(want.save_request),
                                  CodeBits'(rsp_payload.save_request));
               if (rsp_payload.reset_request !== want.reset_request)
                  report_mismatch("reset_request", CodeBits'(want.reset_request),
                                  CodeBits'(rsp_payload.reset_request));
            end
         end
         if (req_valid && !req_stall) begin
            predict_report(req_payload, want);
            expected_reports.push_back(want);
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

FILE: tb/sv/debounced_supply_temp_fault_monitor_tb.sv
`timescale 1ns / 1ps
module debounced_supply_temp_fault_monitor_tb import dstfm_pkg::*; ();

   localparam int IdleLimit   = 500;
   localparam int DrainCycles = 4;
   localparam int EndCycles   = 8;
   localparam int MaxReading  = 4095;
   localparam int ChBus  = 0;
   localparam int ChHs   = 1;
   localparam int ChNtc  = 2;
   localparam int ChRail = 3;
   localparam logic [CsrIdxBits-1:0] FirstUnusedReg = RegPersist + 1'b1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIdxBits-1:0]  csr_index;
   logic [ReadingBits-1:0] csr_wdata;

   int fail_count, pending_count, checked_count;
   int beats_sent = 0, writes_done = 0, settings_done = 0;
   int idle_cycles = 0;
   int stall_left = 0, quiet_left = 0;
   int req_gap_rate = 0;
   bit idle_on = 1'b1;

   // what the stimulus believes the registers hold, used only to shape readings
   logic [ReadingBits-1:0] cfg [8];

   debounced_supply_temp_fault_monitor u_top (.*);

   fault_monitor_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver back-pressure: bursts of stall with quiet stretches between
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (quiet_left > 0) begin
         rsp_stall <= 1'b0;
         quiet_left--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 7) == 0) quiet_left = $urandom_range(20, 80);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_payload_type make_beat(input logic tick, input int bus, input int hs,
                                                 input int ntc, input int rail,
                                                 input logic ext);
      req_payload_type p;
      p.tick             = tick;
      p.bus_reading      = bus[ReadingBits-1:0];
      p.heatsink_reading = hs[ReadingBits-1:0];
      p.ntc_reading      = ntc[ReadingBits-1:0];
      p.rail_reading     = rail[ReadingBits-1:0];
      p.external_fault   = ext;
      return p;
   endfunction

   // in-range window is [lo, hi]; out of range means anything outside it
   function automatic logic [ReadingBits-1:0] pick_reading(input int lo, input int hi,
                                                           input bit want_out);
      bit below_ok, above_ok;
      below_ok = lo > 0;
      above_ok = hi < MaxReading;
      if (lo > hi) return ReadingBits'($urandom_range(0, MaxReading));
      if (want_out && (below_ok || above_ok)) begin
         if (below_ok && (!above_ok || $urandom_range(0, 1) == 1)) begin
            if ($urandom_range(0, 3) == 0) return ReadingBits'(lo - 1);
            return ReadingBits'($urandom_range(0, lo - 1));
         end
         if ($urandom_range(0, 3) == 0) return ReadingBits'(hi + 1);
         return ReadingBits'($urandom_range(hi + 1, MaxReading));
      end
      case ($urandom_range(0, 5))
         0: return ReadingBits'(lo);
         1: return ReadingBits'(hi);
         default: return ReadingBits'($urandom_range(lo, hi));
      endcase
   endfunction

   // called at a falling edge; leaves csr_valid high so writes can go back to back
   task automatic write_reg(input logic [CsrIdxBits-1:0] idx, input int data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[ReadingBits-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      if (idx <= RegPersist) cfg[idx[2:0]] = data[ReadingBits-1:0];
      writes_done++;
   endtask

   // called at a falling edge; leaves req_valid high for the next beat
   task automatic send_beat(input req_payload_type p);
      int gap;
      if (idle_on && $urandom_range(1, 8) <= req_gap_rate) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // channels in 'active' alternate in-range and out-of-range runs around the
   // persistence length; the others get unshaped readings
   task automatic run_phase(input int count, input logic [3:0] active, input int ext_odds);
      int                     run_left [4];
      bit                     run_out [4];
      logic [ReadingBits-1:0] rd [4];
      int                     lo, hi, span, ch, k;
      req_payload_type        p;
      csr_valid <= 1'b0;
      req_gap_rate = $urandom_range(0, 3);
      settings_done++;
      for (ch = 0; ch < 4; ch++) begin
         run_left[ch] = 0;
         run_out[ch]  = 1'b1;
      end
      span = int'(cfg[RegPersist][TicksBits-1:0]) + 3;
      for (k = 0; k < count; k++) begin
         for (ch = 0; ch < 4; ch++) begin
            if (run_left[ch] == 0) begin
               run_out[ch]  = !run_out[ch];
               run_left[ch] = run_out[ch] ? $urandom_range(1, span) : $urandom_range(1, 6);
            end
            run_left[ch]--;
            case (ch)
               ChBus: begin
                  lo = int'(cfg[RegBusLow]);
                  hi = int'(cfg[RegBusHigh]);
               end
               ChHs: begin
                  lo = 0;
                  hi = int'(cfg[RegHeatsink]);
               end
               ChNtc: begin
                  lo = int'(cfg[RegNtc]);
                  hi = MaxReading;
               end
               default: begin
                  lo = int'(cfg[RegRailLow]);
                  hi = int'(cfg[RegRailHigh]);
               end
            endcase
            if (active[ch]) rd[ch] = pick_reading(lo, hi, run_out[ch]);
            else rd[ch] = ReadingBits'($urandom_range(0, MaxReading));
         end
         p.tick             = ($urandom_range(0, 5) != 0);
         p.bus_reading      = rd[ChBus];
         p.heatsink_reading = rd[ChHs];
         p.ntc_reading      = rd[ChNtc];
         p.rail_reading     = rd[ChRail];
         p.external_fault   = (ext_odds != 0) && ($urandom_range(1, ext_odds) == 1);
         send_beat(p);
      end
   endtask

   initial begin : stimulus
      int lo, hi, k;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      cfg[RegBusHigh]    = 12'd3800;
      cfg[RegBusLow]     = 12'd2000;
      cfg[RegBusRecover] = 12'd2800;
      cfg[RegHeatsink]   = 12'd3000;
      cfg[RegNtc]        = 12'd1000;
      cfg[RegRailLow]    = 12'd1000;
      cfg[RegRailHigh]   = 12'd1600;
      cfg[RegPersist]    = 12'(PersistReset);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults after reset; counters start high, so none of these can latch
      req_gap_rate = 2;
      settings_done++;
      send_beat(make_beat(1'b0, 0, 0, 0, 0, 1'b0));
      send_beat(make_beat(1'b0, 4095, 4095, 4095, 4095, 1'b0));
      send_beat(make_beat(1'b1, 3000, 1000, 2000, 1300, 1'b0));
      send_beat(make_beat(1'b1, 0, 0, 0, 0, 1'b0));
      send_beat(make_beat(1'b1, 4095, 4095, 4095, 4095, 1'b0));
      send_beat(make_beat(1'b1, 3800, 3000, 1000, 1000, 1'b0));
      send_beat(make_beat(1'b1, 2000, 3001, 999, 1600, 1'b0));
      send_beat(make_beat(1'b1, 3801, 0, 4095, 999, 1'b0));
      send_beat(make_beat(1'b1, 1999, 2999, 1001, 1601, 1'b0));
      send_beat(make_beat(1'b1, 2801, 1000, 2000, 1300, 1'b0));
      send_beat(make_beat(1'b1, 2800, 1000, 2000, 1300, 1'b0));
      send_beat(make_beat(1'b0, 4095, 4095, 0, 0, 1'b0));
      send_beat(make_beat(1'b1, 'hAAA, 'h555, 'hAAA, 'h555, 1'b0));
      send_beat(make_beat(1'b0, 'h555, 'hAAA, 'h555, 'hAAA, 1'b0));
      send_beat(make_beat(1'b1, 'h555, 'hAAA, 'h555, 'hAAA, 1'b0));
      send_beat(make_beat(1'b1, 'hAAA, 'h555, 'hAAA, 'h555, 1'b0));

      // every limit at its extreme: nothing can go out of range
      wait_idle();
      write_reg(RegBusHigh, MaxReading);
      write_reg(RegBusLow, 0);
      write_reg(RegBusRecover, MaxReading);
      write_reg(RegHeatsink, MaxReading);
      write_reg(RegNtc, 0);
      write_reg(RegRailLow, 0);
      write_reg(RegRailHigh, MaxReading);
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'd255});
      run_phase(60, 4'b0000, 0);

      // rail window alone
      wait_idle();
      lo = $urandom_range(100, 2000);
      write_reg(RegRailLow, lo);
      write_reg(RegRailHigh, lo + $urandom_range(50, 1500));
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'($urandom_range(2, 10))});
      run_phase(100, 4'(1 << ChRail), 0);

      // NTC with a zero reload: faults on the first out-of-range tick after a reload
      wait_idle();
      write_reg(RegNtc, $urandom_range(500, 3500));
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'd0});
      run_phase(80, 4'(1 << ChNtc), 0);

      wait_idle();
      write_reg(RegHeatsink, $urandom_range(500, 3500));
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'd1});
      run_phase(80, 4'(1 << ChHs), 0);

      // bus window, then junk written to unused indexes must change nothing
      wait_idle();
      lo = $urandom_range(500, 2500);
      hi = lo + $urandom_range(300, 1500);
      write_reg(RegBusLow, lo);
      write_reg(RegBusHigh, hi);
      write_reg(RegBusRecover, $urandom_range(lo, hi));
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'($urandom_range(3, 20))});
      for (k = 0; k < 8; k++)
         write_reg(FirstUnusedReg + CsrIdxBits'(k), $urandom_range(0, MaxReading));
      run_phase(150, 4'(1 << ChBus), 0);

      // bus limits in any order, recovery level at zero
      wait_idle();
      write_reg(RegBusLow, $urandom_range(0, MaxReading));
      write_reg(RegBusHigh, $urandom_range(0, MaxReading));
      write_reg(RegBusRecover, 0);
      write_reg(RegPersist, {4'($urandom_range(0, 15)), 8'($urandom_range(0, 4))});
      run_phase(60, 4'(1 << ChBus), 0);

      // last part runs at full rate; external faults take over the latch
      wait_idle();
      idle_on = 1'b0;
      write_reg(RegBusLow, 1000);
      write_reg(RegBusHigh, 3000);
      write_reg(RegBusRecover, 2000);
      run_phase(60, 4'(1 << ChBus), 4);

      wait_idle();
      repeat (EndCycles) @(posedge clock);
      $display("checked %0d results from %0d request beats, %0d register writes, %0d settings",
               checked_count, beats_sent, writes_done, settings_done);
      $display("fault latch walked from clear through rail, NTC, heatsink, bus to external");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
